[hw/rtl/assert_macros.svh]
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define SBCM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define SBCM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[hw/rtl/sbcm_pkg.sv]
// Shared constants, step codes and control structs of the slice blend metric block.
`default_nettype none

package sbcm_pkg;

  localparam int MAX_VOXELS = 16777216;
  localparam int PIXEL_BITS = 16;

  localparam int PIX_W      = 16;
  localparam int MASK_W     = 8;
  localparam int WEIGHT_W   = 16;
  localparam int OFFSET_W   = 25;
  localparam int BLEND_W    = 28;
  localparam int METRIC_W   = 64;
  localparam int SUM_W      = 52;
  localparam int SQ_W       = 64;
  localparam int ERR_W      = 64;
  localparam int COUNT_W    = $clog2(MAX_VOXELS) + 1;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 25;
  localparam int DIV_STEPS  = 64;
  localparam int SQRT_STEPS = 32;

  localparam logic [PIX_W-1:0]  PIX_MASK     = PIX_W'((32'd1 << PIXEL_BITS) - 32'd1);
  localparam logic [MASK_W-1:0] MASK_SKIP    = 8'd0;
  localparam logic [MASK_W-1:0] MASK_CLASS_A = 8'd255;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MASK_EN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BOTTOM_W = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP_W    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET   = 2'd3;

  // Sequencer steps, also the controller state codes
  localparam int OP_W = 5;
  localparam logic [OP_W-1:0] OP_IDLE    = 5'd0;
  localparam logic [OP_W-1:0] OP_MUL     = 5'd1;
  localparam logic [OP_W-1:0] OP_BLEND   = 5'd2;
  localparam logic [OP_W-1:0] OP_SQ      = 5'd3;
  localparam logic [OP_W-1:0] OP_ACC     = 5'd4;
  localparam logic [OP_W-1:0] OP_CHK     = 5'd5;
  localparam logic [OP_W-1:0] OP_DIV_MA  = 5'd6;
  localparam logic [OP_W-1:0] OP_DIV_MB  = 5'd7;
  localparam logic [OP_W-1:0] OP_DIV_QA  = 5'd8;
  localparam logic [OP_W-1:0] OP_DIV_QB  = 5'd9;
  localparam logic [OP_W-1:0] OP_MUL_AL  = 5'd10;
  localparam logic [OP_W-1:0] OP_MUL_AH  = 5'd11;
  localparam logic [OP_W-1:0] OP_MUL_BL  = 5'd12;
  localparam logic [OP_W-1:0] OP_MUL_BH  = 5'd13;
  localparam logic [OP_W-1:0] OP_SQRT_A  = 5'd14;
  localparam logic [OP_W-1:0] OP_SQRT_B  = 5'd15;
  localparam logic [OP_W-1:0] OP_MUL_SD  = 5'd16;
  localparam logic [OP_W-1:0] OP_SQRT_D  = 5'd17;
  localparam logic [OP_W-1:0] OP_CHKD    = 5'd18;
  localparam logic [OP_W-1:0] OP_DIV_M   = 5'd19;
  localparam logic [OP_W-1:0] OP_FIN     = 5'd20;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            start;
    logic            load;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic both;
    logic den_zero;
    logic last;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

[hw/rtl/sbcm_intf.sv]
// Valid/ready channel interfaces for voxel input and result output.
`default_nettype none

interface sbcm_in_if;
  import sbcm_pkg::*;
  logic              valid;
  logic              ready;
  logic [PIX_W-1:0]  bottom_pixel;
  logic [PIX_W-1:0]  middle_pixel;
  logic [PIX_W-1:0]  top_pixel;
  logic [PIX_W-1:0]  target_pixel;
  logic [MASK_W-1:0] mask_value;
  logic              last_voxel;

  modport source (output valid, bottom_pixel, middle_pixel, top_pixel, target_pixel,
                  mask_value, last_voxel, input ready);
  modport sink (input valid, bottom_pixel, middle_pixel, top_pixel, target_pixel,
                mask_value, last_voxel, output ready);
endinterface

interface sbcm_out_if;
  import sbcm_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [BLEND_W-1:0]  blended_pixel;
  logic signed [METRIC_W-1:0] metric;
  logic                       metric_valid;
  logic                       used_separation;

  modport source (output valid, blended_pixel, metric, metric_valid, used_separation,
                  input ready);
  modport sink (input valid, blended_pixel, metric, metric_valid, used_separation,
                output ready);
endinterface

`default_nettype wire

[hw/rtl/sbcm_ctrl.sv]
// Sequencer state machine: voxel steps and the end-of-frame metric sequence.
`default_nettype none

module sbcm_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  sbcm_pkg::status_t status,
  output logic             in_ready,
  output sbcm_pkg::cmd_t   cmd
);
  import sbcm_pkg::*;

  logic [OP_W-1:0] state_r, state_nxt;
  logic            start_r, start_nxt;
  logic            step_done;

  // done from the iterative units counts only after their load cycle
  assign step_done = !start_r && status.done;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      OP_IDLE:   if (in_valid) state_nxt = OP_MUL;
      OP_MUL:    state_nxt = OP_BLEND;
      OP_BLEND:  state_nxt = OP_SQ;
      OP_SQ:     state_nxt = OP_ACC;
      OP_ACC:    state_nxt = OP_CHK;
      OP_CHK:    state_nxt = (status.last && status.both) ? OP_DIV_MA : OP_FIN;
      OP_DIV_MA: if (step_done) state_nxt = OP_DIV_MB;
      OP_DIV_MB: if (step_done) state_nxt = OP_DIV_QA;
      OP_DIV_QA: if (step_done) state_nxt = OP_DIV_QB;
      OP_DIV_QB: if (step_done) state_nxt = OP_MUL_AL;
      OP_MUL_AL: if (step_done) state_nxt = OP_MUL_AH;
      OP_MUL_AH: if (step_done) state_nxt = OP_MUL_BL;
      OP_MUL_BL: if (step_done) state_nxt = OP_MUL_BH;
      OP_MUL_BH: if (step_done) state_nxt = OP_SQRT_A;
      OP_SQRT_A: if (step_done) state_nxt = OP_SQRT_B;
      OP_SQRT_B: if (step_done) state_nxt = OP_MUL_SD;
      OP_MUL_SD: if (step_done) state_nxt = OP_SQRT_D;
      OP_SQRT_D: if (step_done) state_nxt = OP_CHKD;
      OP_CHKD:   state_nxt = status.den_zero ? OP_FIN : OP_DIV_M;
      OP_DIV_M:  if (step_done) state_nxt = OP_FIN;
      OP_FIN:    if (status.out_free) state_nxt = OP_IDLE;
      default:   state_nxt = OP_IDLE;
    endcase
  end

  // start marks the first cycle of each step; it loads the shared units
  assign start_nxt = (state_nxt != state_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= OP_IDLE;
      start_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      start_r <= start_nxt;
    end
  end

  assign in_ready  = (state_r == OP_IDLE);
  assign cmd.op    = state_r;
  assign cmd.start = start_r;
  assign cmd.load  = (state_r == OP_IDLE) && in_valid;

endmodule

`default_nettype wire

[hw/rtl/sbcm_dp.sv]
// Datapath: config registers, blend arithmetic, accumulators, shared div/sqrt/mul units.
`default_nettype none

module sbcm_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  sbcm_pkg::cmd_t                      cmd,
  input  logic                                cfg_we,
  input  logic [sbcm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sbcm_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [sbcm_pkg::PIX_W-1:0]          bottom_pixel,
  input  logic [sbcm_pkg::PIX_W-1:0]          middle_pixel,
  input  logic [sbcm_pkg::PIX_W-1:0]          top_pixel,
  input  logic [sbcm_pkg::PIX_W-1:0]          target_pixel,
  input  logic [sbcm_pkg::MASK_W-1:0]         mask_value,
  input  logic                                last_voxel,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic signed [sbcm_pkg::BLEND_W-1:0] blended_pixel,
  output logic signed [sbcm_pkg::METRIC_W-1:0] metric,
  output logic                                metric_valid,
  output logic                                used_separation,
  output sbcm_pkg::status_t                   status
);
  import sbcm_pkg::*;

  // configuration
  logic                       mask_en_r;
  logic signed [WEIGHT_W-1:0] bot_w_r, top_w_r;
  logic signed [OFFSET_W-1:0] offset_r;

  // captured voxel
  logic [PIX_W-1:0]  bot_r, mid_r, top_r, tgt_r;
  logic [MASK_W-1:0] mask_r;
  logic              last_r;

  // blend pipeline
  logic signed [32:0]        pb_r, pt_r;
  logic signed [34:0]        q12;
  logic signed [30:0]        v_floor;
  logic signed [31:0]        blend_full;
  logic signed [BLEND_W-1:0] blend_sat, blend_r;
  logic signed [29:0]        diff;
  logic [28:0]               adiff;
  logic [BLEND_W-1:0]        ablend;
  logic [57:0]               esq_r;
  logic [55:0]               bsq_r;

  // accumulators
  logic [ERR_W-1:0]        err_sum_r;
  logic signed [SUM_W-1:0] sum_a_r, sum_b_r;
  logic [SQ_W-1:0]         sq_a_r, sq_b_r;
  logic [COUNT_W-1:0]      cnt_a_r, cnt_b_r;
  logic                    scored, is_class_a;
  logic [ERR_W:0]          err_add;
  logic [SQ_W:0]           sq_a_add, sq_b_add;
  logic signed [SUM_W:0]   sum_a_add, sum_b_add;

  // frame metric registers
  logic signed [SUM_W-1:0] ma_r, mb_r;
  logic [SQ_W-1:0]         msq_a_r, msq_b_r, m2_a_r, m2_b_r, prod_r;
  logic [31:0]             sd_a_r, sd_b_r, den_r;
  logic [SUM_W-1:0]        abs_sum_a, abs_sum_b, am_a, am_b;
  logic [SQ_W-1:0]         var_a, var_b;
  logic signed [SUM_W:0]   dm;
  logic [SUM_W:0]          adm;
  logic                    both;

  // shared divider
  logic [63:0] div_quo_r;
  logic [31:0] div_rem_r, div_den_r;
  logic [6:0]  div_cnt_r;
  logic [63:0] div_num_sel;
  logic [31:0] div_den_sel;
  logic [32:0] div_trial;
  logic        div_ge, div_op, div_done;

  // shared square root
  logic [63:0] sq_v_r, sq_res_r, sq_bit_r;
  logic [5:0]  sq_cnt_r;
  logic [63:0] sq_in_sel, sq_sum;
  logic        sq_ge, sq_op, sq_done;

  // shared multiplier
  logic [63:0] mul_r;
  logic [31:0] mul_a_sel, mul_b_sel;
  logic        mul_op, mul_done_r;

  logic        out_valid_r, out_free;
  logic signed [BLEND_W-1:0]  out_blend_r;
  logic signed [METRIC_W-1:0] out_metric_r, metric_sel;
  logic        out_mv_r, out_sep_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_en_r <= 1'b0;
      bot_w_r   <= '0;
      top_w_r   <= '0;
      offset_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MASK_EN:  mask_en_r <= cfg_data[0];
        CFG_BOTTOM_W: bot_w_r   <= cfg_data[WEIGHT_W-1:0];
        CFG_TOP_W:    top_w_r   <= cfg_data[WEIGHT_W-1:0];
        CFG_OFFSET:   offset_r  <= cfg_data[OFFSET_W-1:0];
        default:      ;
      endcase
    end
  end

  // voxel capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bot_r  <= bottom_pixel & PIX_MASK;
      mid_r  <= middle_pixel & PIX_MASK;
      top_r  <= top_pixel & PIX_MASK;
      tgt_r  <= target_pixel & PIX_MASK;
      mask_r <= mask_value;
      last_r <= last_voxel;
    end
  end

  // blend: Q.12 sum rounded to Q.8, offset, saturate to 28 bits
  assign q12 = 35'(pb_r) + 35'(pt_r) + $signed({7'd0, mid_r, 12'd0}) + 35'sd8;
  assign v_floor    = 31'(q12 >>> 4);
  assign blend_full = 32'(v_floor) + 32'(offset_r);
  always_comb begin
    if (blend_full[31:BLEND_W-1] == '0 || blend_full[31:BLEND_W-1] == '1) begin
      blend_sat = blend_full[BLEND_W-1:0];
    end else if (blend_full[31]) begin
      blend_sat = {1'b1, {(BLEND_W-1){1'b0}}};
    end else begin
      blend_sat = {1'b0, {(BLEND_W-1){1'b1}}};
    end
  end

  assign diff   = $signed({6'd0, tgt_r, 8'd0}) - 30'(blend_r);
  assign adiff  = diff[29] ? 29'(-diff) : diff[28:0];
  assign ablend = blend_r[BLEND_W-1] ? BLEND_W'(-blend_r) : blend_r;

  always_ff @(posedge clk) begin
    if (cmd.op == OP_MUL) begin
      pb_r <= bot_w_r * $signed({1'b0, bot_r});
      pt_r <= top_w_r * $signed({1'b0, top_r});
    end
    if (cmd.op == OP_BLEND) blend_r <= blend_sat;
    if (cmd.op == OP_SQ) begin
      esq_r <= 58'(adiff) * 58'(adiff);
      bsq_r <= 56'(ablend) * 56'(ablend);
    end
  end

  // saturating accumulation
  assign scored     = !mask_en_r || (mask_r != MASK_SKIP);
  assign is_class_a = (mask_r == MASK_CLASS_A);
  assign err_add    = {1'b0, err_sum_r} + (ERR_W + 1)'(esq_r);
  assign sq_a_add   = {1'b0, sq_a_r} + (SQ_W + 1)'(bsq_r);
  assign sq_b_add   = {1'b0, sq_b_r} + (SQ_W + 1)'(bsq_r);
  assign sum_a_add  = (SUM_W + 1)'(sum_a_r) + (SUM_W + 1)'(blend_r);
  assign sum_b_add  = (SUM_W + 1)'(sum_b_r) + (SUM_W + 1)'(blend_r);
  assign both       = (cnt_a_r != '0) && (cnt_b_r != '0);

  always_ff @(posedge clk) begin
    if (!rst_n || (cmd.op == OP_FIN && out_free && last_r)) begin
      err_sum_r <= '0;
      sum_a_r   <= '0;
      sum_b_r   <= '0;
      sq_a_r    <= '0;
      sq_b_r    <= '0;
      cnt_a_r   <= '0;
      cnt_b_r   <= '0;
    end else if (cmd.op == OP_ACC && scored) begin
      err_sum_r <= (err_add[ERR_W:ERR_W-1] != 2'b00) ? {1'b0, {(ERR_W-1){1'b1}}}
                                                    : err_add[ERR_W-1:0];
      if (mask_en_r && is_class_a) begin
        sum_a_r <= (sum_a_add[SUM_W] != sum_a_add[SUM_W-1])
                   ? {sum_a_add[SUM_W], {(SUM_W-1){~sum_a_add[SUM_W]}}}
                   : sum_a_add[SUM_W-1:0];
        sq_a_r  <= sq_a_add[SQ_W] ? '1 : sq_a_add[SQ_W-1:0];
        if (cnt_a_r != '1) cnt_a_r <= cnt_a_r + 1'b1;
      end else if (mask_en_r) begin
        sum_b_r <= (sum_b_add[SUM_W] != sum_b_add[SUM_W-1])
                   ? {sum_b_add[SUM_W], {(SUM_W-1){~sum_b_add[SUM_W]}}}
                   : sum_b_add[SUM_W-1:0];
        sq_b_r  <= sq_b_add[SQ_W] ? '1 : sq_b_add[SQ_W-1:0];
        if (cnt_b_r != '1) cnt_b_r <= cnt_b_r + 1'b1;
      end
    end
  end

  // magnitudes and differences for the class statistics
  assign abs_sum_a = sum_a_r[SUM_W-1] ? SUM_W'(-sum_a_r) : sum_a_r;
  assign abs_sum_b = sum_b_r[SUM_W-1] ? SUM_W'(-sum_b_r) : sum_b_r;
  assign am_a  = ma_r[SUM_W-1] ? SUM_W'(-ma_r) : ma_r;
  assign am_b  = mb_r[SUM_W-1] ? SUM_W'(-mb_r) : mb_r;
  assign var_a = (msq_a_r > m2_a_r) ? (msq_a_r - m2_a_r) : '0;
  assign var_b = (msq_b_r > m2_b_r) ? (msq_b_r - m2_b_r) : '0;
  assign dm    = (SUM_W + 1)'(ma_r) - (SUM_W + 1)'(mb_r);
  assign adm   = dm[SUM_W] ? (SUM_W + 1)'(-dm) : dm;

  // operand selection for the shared units
  always_comb begin
    div_num_sel = '0;
    div_den_sel = '0;
    sq_in_sel   = '0;
    mul_a_sel   = '0;
    mul_b_sel   = '0;
    case (cmd.op)
      OP_DIV_MA: begin div_num_sel = 64'(abs_sum_a); div_den_sel = 32'(cnt_a_r); end
      OP_DIV_MB: begin div_num_sel = 64'(abs_sum_b); div_den_sel = 32'(cnt_b_r); end
      OP_DIV_QA: begin div_num_sel = sq_a_r; div_den_sel = 32'(cnt_a_r); end
      OP_DIV_QB: begin div_num_sel = sq_b_r; div_den_sel = 32'(cnt_b_r); end
      OP_DIV_M:  begin div_num_sel = {adm[47:0], 16'd0}; div_den_sel = den_r; end
      OP_MUL_AL: begin mul_a_sel = am_a[31:0]; mul_b_sel = am_a[31:0]; end
      OP_MUL_AH: begin mul_a_sel = 32'(am_a[SUM_W-1:32]); mul_b_sel = am_a[31:0]; end
      OP_MUL_BL: begin mul_a_sel = am_b[31:0]; mul_b_sel = am_b[31:0]; end
      OP_MUL_BH: begin mul_a_sel = 32'(am_b[SUM_W-1:32]); mul_b_sel = am_b[31:0]; end
      OP_MUL_SD: begin mul_a_sel = sd_a_r; mul_b_sel = sd_b_r; end
      OP_SQRT_A: sq_in_sel = var_a;
      OP_SQRT_B: sq_in_sel = var_b;
      OP_SQRT_D: sq_in_sel = prod_r;
      default:   ;
    endcase
  end

  assign div_op = (cmd.op == OP_DIV_MA) || (cmd.op == OP_DIV_MB) || (cmd.op == OP_DIV_QA) ||
                  (cmd.op == OP_DIV_QB) || (cmd.op == OP_DIV_M);
  assign sq_op  = (cmd.op == OP_SQRT_A) || (cmd.op == OP_SQRT_B) || (cmd.op == OP_SQRT_D);
  assign mul_op = (cmd.op == OP_MUL_AL) || (cmd.op == OP_MUL_AH) || (cmd.op == OP_MUL_BL) ||
                  (cmd.op == OP_MUL_BH) || (cmd.op == OP_MUL_SD);

  // restoring divider, one quotient bit per cycle
  assign div_trial = {div_rem_r, div_quo_r[63]};
  assign div_ge    = (div_trial >= {1'b0, div_den_r});
  assign div_done  = (div_cnt_r == 7'(DIV_STEPS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_cnt_r <= '0;
    end else if (div_op && cmd.start) begin
      div_cnt_r <= '0;
    end else if (div_op && !div_done) begin
      div_cnt_r <= div_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (div_op && cmd.start) begin
      div_quo_r <= div_num_sel;
      div_rem_r <= '0;
      div_den_r <= div_den_sel;
    end else if (div_op && !div_done) begin
      div_quo_r <= {div_quo_r[62:0], div_ge};
      div_rem_r <= div_ge ? 32'(div_trial - {1'b0, div_den_r}) : div_trial[31:0];
    end
  end

  // bitwise integer square root, one result bit per cycle
  assign sq_sum  = sq_res_r + sq_bit_r;
  assign sq_ge   = (sq_v_r >= sq_sum);
  assign sq_done = (sq_cnt_r == 6'(SQRT_STEPS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_cnt_r <= '0;
    end else if (sq_op && cmd.start) begin
      sq_cnt_r <= '0;
    end else if (sq_op && !sq_done) begin
      sq_cnt_r <= sq_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (sq_op && cmd.start) begin
      sq_v_r   <= sq_in_sel;
      sq_res_r <= '0;
      sq_bit_r <= 64'd1 << 62;
    end else if (sq_op && !sq_done) begin
      sq_v_r   <= sq_ge ? (sq_v_r - sq_sum) : sq_v_r;
      sq_res_r <= sq_ge ? ((sq_res_r >> 1) + sq_bit_r) : (sq_res_r >> 1);
      sq_bit_r <= sq_bit_r >> 2;
    end
  end

  // 32x32 multiplier, result ready in the cycle after load
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_done_r <= 1'b0;
    end else begin
      mul_done_r <= mul_op && cmd.start;
    end
  end

  always_ff @(posedge clk) begin
    if (mul_op && cmd.start) mul_r <= 64'(mul_a_sel) * 64'(mul_b_sel);
  end

  // unit results into the metric registers
  always_ff @(posedge clk) begin
    if (!cmd.start) begin
      case (cmd.op)
        OP_DIV_MA: if (div_done) ma_r <= sum_a_r[SUM_W-1] ? SUM_W'(-div_quo_r[SUM_W-1:0])
                                                          : div_quo_r[SUM_W-1:0];
        OP_DIV_MB: if (div_done) mb_r <= sum_b_r[SUM_W-1] ? SUM_W'(-div_quo_r[SUM_W-1:0])
                                                          : div_quo_r[SUM_W-1:0];
        OP_DIV_QA: if (div_done) msq_a_r <= div_quo_r;
        OP_DIV_QB: if (div_done) msq_b_r <= div_quo_r;
        OP_MUL_AL: if (mul_done_r) m2_a_r <= mul_r;
        OP_MUL_AH: if (mul_done_r) m2_a_r <= m2_a_r + {mul_r[30:0], 33'd0};
        OP_MUL_BL: if (mul_done_r) m2_b_r <= mul_r;
        OP_MUL_BH: if (mul_done_r) m2_b_r <= m2_b_r + {mul_r[30:0], 33'd0};
        OP_SQRT_A: if (sq_done) sd_a_r <= sq_res_r[31:0];
        OP_SQRT_B: if (sq_done) sd_b_r <= sq_res_r[31:0];
        OP_MUL_SD: if (mul_done_r) prod_r <= mul_r;
        OP_SQRT_D: if (sq_done) den_r <= sq_res_r[31:0];
        default:   ;
      endcase
    end
  end

  // result selection and output register
  always_comb begin
    if (!last_r) begin
      metric_sel = '0;
    end else if (!both) begin
      metric_sel = $signed(err_sum_r);
    end else if (den_r == '0) begin
      metric_sel = {1'b1, {(METRIC_W-1){1'b0}}};
    end else begin
      metric_sel = $signed(~div_quo_r + 64'd1);
    end
  end

  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == OP_FIN && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_FIN && out_free) begin
      out_blend_r  <= blend_r;
      out_metric_r <= metric_sel;
      out_mv_r     <= last_r;
      out_sep_r    <= last_r && both;
    end
  end

  assign out_valid       = out_valid_r;
  assign blended_pixel   = out_blend_r;
  assign metric          = out_metric_r;
  assign metric_valid    = out_mv_r;
  assign used_separation = out_sep_r;

  assign status.done = div_op ? div_done : (sq_op ? sq_done : mul_done_r);
  assign status.both     = both;
  assign status.den_zero = (den_r == '0);
  assign status.last     = last_r;
  assign status.out_free = out_free;

endmodule

`default_nettype wire

[hw/rtl/slice_blend_contrast_metric.sv]
// Top level of the slice blend contrast metric block.
// A voxel transaction runs from acceptance to the next ready through these steps:
// capture, two weight products, blend and saturate, two squares, accumulate, a
// decision step and the write into the output register, which lets the next
// voxel in while a result waits; the write stalls while an earlier result still
// waits. A last voxel scored by class separation also runs the shared units in
// sequence: five 64-step restoring divisions, three 32-step square roots,
// five passes through one 32x32 multiplier and one denominator check.
// A zero denominator skips the final division.
// A last voxel without both classes goes from the decision step to the write.
// Accumulators clear on the result of every last voxel; no clearing pass.
`default_nettype none

module slice_blend_contrast_metric (
  input  logic                            clk,
  input  logic                            rst_n,
  sbcm_in_if.sink                         in_ch,
  sbcm_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [sbcm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sbcm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sbcm_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    in_ready;

  sbcm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .status   (status),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  sbcm_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .bottom_pixel    (in_ch.bottom_pixel),
    .middle_pixel    (in_ch.middle_pixel),
    .top_pixel       (in_ch.top_pixel),
    .target_pixel    (in_ch.target_pixel),
    .mask_value      (in_ch.mask_value),
    .last_voxel      (in_ch.last_voxel),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .blended_pixel   (out_ch.blended_pixel),
    .metric          (out_ch.metric),
    .metric_valid    (out_ch.metric_valid),
    .used_separation (out_ch.used_separation),
    .status          (status)
  );

  assign in_ch.ready = in_ready;

endmodule

`default_nettype wire

[hw/rtl/sbcm_checker.sv]
// Port-level assertions for the slice blend contrast metric block, with bind.
`default_nettype none
`include "assert_macros.svh"

module sbcm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] metric,
  input logic        metric_valid,
  input logic        used_separation
);

  // a stalled result holds its metric
  `SBCM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(metric))

  // one voxel at a time: no back-to-back acceptance
  `SBCM_ASSERT_NEXT(a_in_busy, clk, rst_n, in_valid && in_ready, !in_ready)

  // non-final voxels carry an empty score
  `SBCM_ASSERT_IMPL(a_no_metric, clk, rst_n, out_valid && !metric_valid, metric == 64'd0 && !used_separation)

  // separation flag only on a frame result
  `SBCM_ASSERT_IMPL(a_sep_final, clk, rst_n, out_valid && used_separation, metric_valid)

endmodule

bind slice_blend_contrast_metric sbcm_checker u_sbcm_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .metric          (out_ch.metric),
  .metric_valid    (out_ch.metric_valid),
  .used_separation (out_ch.used_separation)
);

`default_nettype wire
